@@ rtl/hrsh_pkg.sv @@
// Shared types, register indexes and command codes for the Hadamard rotation sign hash.
package hrsh_pkg;

	// Field widths fixed by the interface.
	localparam int SAMPLE_W  = 16;
	localparam int HASH_W    = 64;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int ADDR_W    = 6;
	localparam int LG_W      = 3;
	localparam int HCNT_W    = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FLIP0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TLOG2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HCOUNT = 3'd4;

	// Source of the store write data.
	localparam logic [1:0] WSEL_SAMPLE = 2'd0;
	localparam logic [1:0] WSEL_SUM    = 2'd1;
	localparam logic [1:0] WSEL_DIFF   = 2'd2;

	// One input beat.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [HASH_W-1:0] hash_bits;
		logic              too_long;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr_a;
		logic [ADDR_W-1:0] rd_addr_b;
		logic              flip_a;
		logic              flip_b;
		logic              bf_capture;
		logic              hash_clr;
		logic              scan_capture;
		logic              scan_neg;
		logic [ADDR_W-1:0] scan_idx;
		logic              clear_all;
	} cmd_t;

endpackage

@@ rtl/hadamard_rotation_sign_hash.sv @@
// Top level of the Hadamard rotation sign hash: controller, datapath and ports.
// Samples load at one beat per cycle while busy is low; a sample without last_sample
// leaves busy low. After the last sample the butterfly rounds over the N = 2^L entries
// in use (L = log2 of the size) run, then the hash bits are collected and done pulses.
// Each butterfly writes its sum, then its difference, on the single write port of the store.
// Reset empties the store through per-entry valid bits at once; no clearing pass.
module hadamard_rotation_sign_hash #(
	parameter int MAX_SIZE    = 64,
	parameter int ROUNDS      = 3,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  hrsh_pkg::item_t                item,
	output logic                           busy,
	output logic                           done,
	output hrsh_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [hrsh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hrsh_pkg::CFG_W-1:0]     cfg_data
);
	import hrsh_pkg::*;

	localparam int LOG2_CAP = $clog2(MAX_SIZE + 1) - 1;
	localparam int AW       = LOG2_CAP;
	localparam int ACC_W    = SAMPLE_BITS + ROUNDS * LOG2_CAP + 1;

	cmd_t              cmd;
	logic [HASH_W-1:0] hash_bits;
	logic              too_long;

	hrsh_ctrl #(
		.LOG2_CAP (LOG2_CAP),
		.AW       (AW),
		.ROUNDS   (ROUNDS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_sample (item.last_sample),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.busy        (busy),
		.done        (done),
		.too_long    (too_long),
		.cmd         (cmd)
	);

	hrsh_datapath #(
		.AW          (AW),
		.ACC_W       (ACC_W),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (item.sample),
		.hash_bits (hash_bits)
	);

	assign result.hash_bits = hash_bits;
	assign result.too_long  = too_long;

	// The result beat lasts one cycle and the block is free right after it.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe held or block stayed busy after emit");

	// A last sample always makes the block busy.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last_sample) |=> busy)
		else $error("last sample did not start the rotation");

	// The store is never written and cleared in the same cycle.
	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.clear_all))
		else $error("store write collides with the clear after emit");

	// A butterfly capture always follows its read.
	a_bf_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bf_capture |-> $past(cmd.rd_en))
		else $error("butterfly captured without a preceding read");

endmodule

@@ rtl/hrsh_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
module hrsh_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

@@ rtl/hrsh_datapath.sv @@
// Datapath: vector store, butterfly arithmetic and hash bit collection.
module hrsh_datapath #(
	parameter int AW          = 6,
	parameter int ACC_W       = 35,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hrsh_pkg::cmd_t                       cmd,
	input  logic signed [hrsh_pkg::SAMPLE_W-1:0] sample,
	output logic [hrsh_pkg::HASH_W-1:0]          hash_bits
);
	import hrsh_pkg::*;

	localparam int DEPTH = 1 << AW;
	localparam int RAW_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

	logic [DEPTH-1:0]        valid_q;
	logic                    va_q;
	logic                    vb_q;
	logic [ACC_W-1:0]        rd_a;
	logic [ACC_W-1:0]        rd_b;
	logic signed [ACC_W-1:0] p;
	logic signed [ACC_W-1:0] q;
	logic signed [ACC_W-1:0] pf;
	logic signed [ACC_W-1:0] qf;
	logic signed [ACC_W-1:0] sum;
	logic signed [ACC_W-1:0] diff;
	logic signed [ACC_W-1:0] diff_q;
	logic signed [ACC_W-1:0] sample_ext;
	logic [RAW_W-1:0]        raw;
	logic [ACC_W-1:0]        wdata;
	logic                    pos_bit;
	logic [HASH_W-1:0]       hash_q;

	// The sample is taken from its low SAMPLE_BITS bits and sign-extended.
	assign raw        = RAW_W'($unsigned(sample));
	assign sample_ext = {{(ACC_W-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw[SAMPLE_BITS-1:0]};

	// Entries never written since the last clear read as zero.
	assign p  = va_q ? $signed(rd_a) : '0;
	assign q  = vb_q ? $signed(rd_b) : '0;
	assign pf = cmd.flip_a ? -p : p;
	assign qf = cmd.flip_b ? -q : q;

	// Butterfly pair.
	assign sum  = pf + qf;
	assign diff = pf - qf;

	// Write data selection.
	always_comb begin
		case (cmd.wr_sel)
			WSEL_SAMPLE: wdata = sample_ext;
			WSEL_SUM:    wdata = sum;
			WSEL_DIFF:   wdata = diff_q;
			default:     wdata = '0;
		endcase
	end

	hrsh_ram #(
		.WIDTH (ACC_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (cmd.wr_en),
		.waddr   (cmd.wr_addr[AW-1:0]),
		.wdata   (wdata),
		.re      (cmd.rd_en),
		.raddr_a (cmd.rd_addr_a[AW-1:0]),
		.raddr_b (cmd.rd_addr_b[AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Valid bits, cleared at once by reset and after every emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (cmd.clear_all) begin
				valid_q <= '0;
			end else if (cmd.wr_en) begin
				valid_q[cmd.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (cmd.rd_en) begin
				va_q <= valid_q[cmd.rd_addr_a[AW-1:0]];
				vb_q <= valid_q[cmd.rd_addr_b[AW-1:0]];
			end
		end
	end

	// The difference is held in a register until the second write.
	always_ff @(posedge clk) begin
		if (cmd.bf_capture) begin
			diff_q <= diff;
		end
	end

	// Strictly positive test, with the folded sign for a one-entry transform.
	assign pos_bit = cmd.scan_neg ? p[ACC_W-1] : (!p[ACC_W-1] && (p != '0));

	// Hash word assembly.
	always_ff @(posedge clk) begin
		if (cmd.hash_clr) begin
			hash_q <= '0;
		end else if (cmd.scan_capture) begin
			hash_q[cmd.scan_idx] <= pos_bit;
		end
	end

	assign hash_bits = hash_q;

endmodule

@@ rtl/hrsh_ctrl.sv @@
// Controller: configuration registers, load counting and the rotation and scan sequencer.
module hrsh_ctrl #(
	parameter int LOG2_CAP = 6,
	parameter int AW       = 6,
	parameter int ROUNDS   = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              last_sample,
	input  logic                              cfg_we,
	input  logic [hrsh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hrsh_pkg::CFG_W-1:0]        cfg_data,
	output logic                              busy,
	output logic                              done,
	output logic                              too_long,
	output hrsh_pkg::cmd_t                    cmd
);
	import hrsh_pkg::*;

	localparam int NW = AW + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_BF_RD  = 3'd1;
	localparam logic [2:0] ST_BF_WR0 = 3'd2;
	localparam logic [2:0] ST_BF_WR1 = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  flip_q [3];
	logic [LG_W-1:0]   tlog2_q;
	logic [HCNT_W-1:0] hcount_q;
	logic [NW-1:0]     lc_q;
	logic              ovf_q;
	logic [1:0]        rnd_q;
	logic [LG_W-1:0]   st_q;
	logic [AW-1:0]     bf_q;
	logic [HCNT_W-1:0] idx_q;
	logic              cap_q;
	logic [ADDR_W-1:0] cap_idx_q;

	logic              accept;
	logic [LG_W-1:0]   lg;
	logic [NW-1:0]     n_sz;
	logic              fits;
	logic [AW-1:0]     lowm;
	logic [AW-1:0]     sbit;
	logic [AW-1:0]     j_addr;
	logic [AW-1:0]     k_addr;
	logic [NW-1:0]     half_m1;
	logic              bf_last;
	logic              st_last;
	logic              rnd_last;
	logic              first_st;
	logic [CFG_W-1:0]  mask_sel;
	logic [HCNT_W-1:0] hc_eff;
	logic [HCNT_W-1:0] cnt;
	logic              scan_go;
	logic              par;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q[0] <= '0;
			flip_q[1] <= '0;
			flip_q[2] <= '0;
			tlog2_q   <= LG_W'(6);
			hcount_q  <= HCNT_W'(HASH_W);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLIP0:  flip_q[0] <= cfg_data;
				REG_FLIP1:  flip_q[1] <= cfg_data;
				REG_FLIP2:  flip_q[2] <= cfg_data;
				REG_TLOG2:  tlog2_q   <= cfg_data[LG_W-1:0];
				REG_HCOUNT: hcount_q  <= cfg_data[HCNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// Transform size in use, saturated to the store.
	assign lg   = (tlog2_q > LG_W'(LOG2_CAP)) ? LG_W'(LOG2_CAP) : tlog2_q;
	assign n_sz = NW'(1) << lg;
	assign fits = lc_q < n_sz;

	assign accept = start && (state_q == ST_IDLE);

	// Butterfly addresses: insert a zero bit at the stage position.
	assign lowm   = ~({AW{1'b1}} << st_q);
	assign j_addr = ((bf_q & ~lowm) << 1) | (bf_q & lowm);
	assign sbit   = AW'(1) << st_q;
	assign k_addr = j_addr | sbit;

	assign half_m1  = (n_sz >> 1) - NW'(1);
	assign bf_last  = ({1'b0, bf_q} == half_m1);
	assign st_last  = (st_q == lg - LG_W'(1));
	assign rnd_last = (rnd_q == 2'(ROUNDS - 1));
	assign first_st = (st_q == '0);
	assign mask_sel = (rnd_q == 2'd0) ? flip_q[0] : ((rnd_q == 2'd1) ? flip_q[1] : flip_q[2]);

	// Number of hash bits to collect.
	assign hc_eff  = (hcount_q > HCNT_W'(HASH_W)) ? HCNT_W'(HASH_W) : hcount_q;
	assign cnt     = (hc_eff > HCNT_W'(n_sz)) ? HCNT_W'(n_sz) : hc_eff;
	assign scan_go = idx_q < cnt;

	// With a single entry the rounds reduce to a sign parity.
	always_comb begin
		par = 1'b0;
		for (int r = 0; r < 3; r++) begin
			if (r < ROUNDS) begin
				par = par ^ flip_q[r][0];
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lc_q      <= '0;
			ovf_q     <= 1'b0;
			rnd_q     <= '0;
			st_q      <= '0;
			bf_q      <= '0;
			idx_q     <= '0;
			cap_q     <= 1'b0;
			cap_idx_q <= '0;
		end else begin
			cap_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (fits) begin
							lc_q <= lc_q + NW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_sample) begin
							rnd_q   <= '0;
							st_q    <= '0;
							bf_q    <= '0;
							idx_q   <= '0;
							state_q <= (lg == '0) ? ST_SCAN : ST_BF_RD;
						end
					end
				end
				ST_BF_RD: begin
					state_q <= ST_BF_WR0;
				end
				ST_BF_WR0: begin
					state_q <= ST_BF_WR1;
				end
				ST_BF_WR1: begin
					state_q <= ST_BF_RD;
					if (bf_last) begin
						bf_q <= '0;
						if (st_last) begin
							st_q <= '0;
							if (rnd_last) begin
								state_q <= ST_SCAN;
							end else begin
								rnd_q <= rnd_q + 2'd1;
							end
						end else begin
							st_q <= st_q + LG_W'(1);
						end
					end else begin
						bf_q <= bf_q + AW'(1);
					end
				end
				ST_SCAN: begin
					cap_q     <= scan_go;
					cap_idx_q <= idx_q[ADDR_W-1:0];
					if (scan_go) begin
						idx_q <= idx_q + HCNT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					lc_q    <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath commands.
	always_comb begin
		cmd              = '0;
		cmd.scan_capture = cap_q;
		cmd.scan_idx     = cap_idx_q;
		cmd.scan_neg     = (lg == '0) && par;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_en    = accept && fits;
				cmd.wr_sel   = WSEL_SAMPLE;
				cmd.wr_addr  = ADDR_W'(lc_q[AW-1:0]);
				cmd.hash_clr = accept && last_sample;
			end
			ST_BF_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_addr_a = ADDR_W'(j_addr);
				cmd.rd_addr_b = ADDR_W'(k_addr);
			end
			ST_BF_WR0: begin
				cmd.bf_capture = 1'b1;
				cmd.flip_a     = first_st && mask_sel[j_addr];
				cmd.flip_b     = first_st && mask_sel[k_addr];
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WSEL_SUM;
				cmd.wr_addr    = ADDR_W'(j_addr);
			end
			ST_BF_WR1: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WSEL_DIFF;
				cmd.wr_addr = ADDR_W'(k_addr);
			end
			ST_SCAN: begin
				cmd.rd_en     = scan_go;
				cmd.rd_addr_a = idx_q[ADDR_W-1:0];
			end
			ST_EMIT: begin
				cmd.clear_all = 1'b1;
			end
			default: ;
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_EMIT);
	assign too_long = ovf_q;

endmodule
